// ===== rtl/core/amcp_pkg.sv =====
// Package for the ASCII motor command parser: byte codes, queue sizing,
// token phase enum and the line and result records. No dependencies.
`default_nettype none

package amcp_pkg;

   localparam logic [7:0] NL_BYTE    = 8'd10;
   localparam logic [7:0] COLON_BYTE = 8'd58;
   localparam logic [7:0] PLUS_BYTE  = 8'd43;
   localparam logic [7:0] MINUS_BYTE = 8'd45;
   localparam logic [7:0] ZERO_BYTE  = 8'd48;
   localparam logic [7:0] NINE_BYTE  = 8'd57;
   localparam logic [7:0] SPACE_BYTE = 8'd32;
   localparam logic [7:0] TAB_BYTE   = 8'd9;
   localparam logic [7:0] CR_BYTE    = 8'd13;

   localparam logic [15:0] DRIVE_LIMIT = 16'd255;

   localparam logic [1:0] FIELD_LEFT  = 2'd0;
   localparam logic [1:0] FIELD_RIGHT = 2'd1;
   localparam logic [1:0] FIELD_CHECK = 2'd2;

   // Depth of the line queue and of the result queue (power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PHASE_SKIP,
      PHASE_BLANK,
      PHASE_NUMBER,
      PHASE_DONE
   } phase_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [15:0] check;
   } line_type;

   typedef struct packed {
      logic [7:0] rt_duty;
      logic       rt_dir;
      logic [7:0] lt_duty;
      logic       lt_dir;
      logic       status;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/amcp_front.sv =====
// Front end of the motor command parser: tokenizes bytes and emits one
// line record per newline. Depends on amcp_pkg.
`default_nettype none

module amcp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_take,
   input  wire logic [7:0]        rx_byte,
   output logic                   line_push,
   output amcp_pkg::line_type     line_data
);
   import amcp_pkg::*;

   logic [1:0]  field_ff, field_in;
   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;

   logic        is_digit;
   logic        is_blank;
   logic [3:0]  digit;
   logic [15:0] acc_next_digit;
   logic [15:0] value;

   assign is_digit = (rx_byte >= ZERO_BYTE) && (rx_byte <= NINE_BYTE);
   assign is_blank = (rx_byte == SPACE_BYTE) || ((rx_byte >= TAB_BYTE) && (rx_byte <= CR_BYTE));
   assign digit    = 4'(rx_byte - ZERO_BYTE);
   // acc * 10 + digit, wrapping at 16 bits
   assign acc_next_digit = {acc_ff[12:0], 3'b000} + {acc_ff[14:0], 1'b0} + {12'd0, digit};
   assign value = neg_ff ? (~acc_ff + 16'd1) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= FIELD_LEFT;
         phase_ff <= PHASE_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         field_ff <= field_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   always_comb begin
      field_in  = field_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      line_push = 1'b0;
      line_data.left  = (field_ff == FIELD_LEFT) ? value : left_ff;
      line_data.right = (field_ff == FIELD_LEFT)  ? 16'd0 :
                        (field_ff == FIELD_RIGHT) ? value : right_ff;
      line_data.check = (field_ff == FIELD_CHECK) ? value : 16'd0;

      if (byte_take) begin
         if (rx_byte == NL_BYTE) begin
            // close the line; missing fields stay zero
            line_push = 1'b1;
            field_in  = FIELD_LEFT;
            left_in   = '0;
            right_in  = '0;
            phase_in  = PHASE_SKIP;
            neg_in    = 1'b0;
            acc_in    = '0;
         end else if ((rx_byte == COLON_BYTE) && (field_ff != FIELD_CHECK)) begin
            if (phase_ff != PHASE_SKIP) begin
               if (field_ff == FIELD_LEFT) begin
                  left_in = value;
               end else begin
                  right_in = value;
               end
               field_in = field_ff + 2'd1;
               phase_in = PHASE_SKIP;
               neg_in   = 1'b0;
               acc_in   = '0;
            end
         end else begin
            case (phase_ff)
               PHASE_SKIP, PHASE_BLANK: begin
                  if (is_blank) begin
                     phase_in = PHASE_BLANK;
                  end else if ((rx_byte == PLUS_BYTE) || (rx_byte == MINUS_BYTE)) begin
                     neg_in   = (rx_byte == MINUS_BYTE);
                     phase_in = PHASE_NUMBER;
                  end else if (is_digit) begin
                     acc_in   = {12'd0, digit};
                     phase_in = PHASE_NUMBER;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               PHASE_NUMBER: begin
                  if (is_digit) begin
                     acc_in = acc_next_digit;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      field_ff != 2'd3)
      else $error("field counter out of range");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_take && (rx_byte == NL_BYTE)) |=>
         (field_ff == FIELD_LEFT) && (phase_ff == PHASE_SKIP) && (acc_ff == 16'd0))
      else $error("line state not cleared after newline");

endmodule

`default_nettype wire

// ===== rtl/core/amcp_line_queue.sv =====
// Short queue of parsed line records between the parser front and the
// drive back end. Depends on amcp_pkg.
`default_nettype none

module amcp_line_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire amcp_pkg::line_type push_data,
   output logic                   full,
   output logic                   empty,
   input  wire logic              pop,
   output amcp_pkg::line_type     pop_data
);
   import amcp_pkg::*;

   line_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("line queue count overflow");

endmodule

`default_nettype wire

// ===== rtl/core/amcp_back.sv =====
// Back end of the motor command parser: checks each line, updates the
// held drive on a match and queues one result per line. Depends on amcp_pkg.
`default_nettype none

module amcp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              line_valid,
   input  wire amcp_pkg::line_type line_data,
   output logic                   line_pop,
   output logic                   res_empty,
   input  wire logic              res_pop,
   output amcp_pkg::result_type   res_data
);
   import amcp_pkg::*;

   function automatic logic [7:0] drive_mag(input logic [15:0] v);
      logic [15:0] mag;
      mag = v[15] ? (~v + 16'd1) : v;
      return (mag > DRIVE_LIMIT) ? 8'hFF : mag[7:0];
   endfunction

   logic [7:0]          rt_duty_ff, rt_duty_in;
   logic                rt_dir_ff, rt_dir_in;
   logic [7:0]          lt_duty_ff, lt_duty_in;
   logic                lt_dir_ff, lt_dir_in;

   result_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   logic                res_full;
   logic                take, do_pop;
   logic [16:0]         sum;
   logic                match;
   logic [7:0]          new_rt_duty, new_lt_duty;
   logic                new_rt_dir, new_lt_dir;
   result_type          res_new;

   assign res_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign res_empty = (count_ff == '0);
   assign take      = line_valid && !res_full;
   assign line_pop  = take;
   assign do_pop    = res_pop && !res_empty;
   assign res_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      sum = {line_data.left[15], line_data.left} + {line_data.right[15], line_data.right};
      match = ({line_data.check[15], line_data.check} == sum);
      new_rt_duty = drive_mag(line_data.right);
      new_lt_duty = drive_mag(line_data.left);
      new_rt_dir  = !line_data.right[15] && (line_data.right != 16'd0);
      new_lt_dir  = line_data.left[15] || (line_data.left == 16'd0);

      rt_duty_in = rt_duty_ff;
      rt_dir_in  = rt_dir_ff;
      lt_duty_in = lt_duty_ff;
      lt_dir_in  = lt_dir_ff;
      if (take && match) begin
         rt_duty_in = new_rt_duty;
         rt_dir_in  = new_rt_dir;
         lt_duty_in = new_lt_duty;
         lt_dir_in  = new_lt_dir;
      end

      res_new.rt_duty = rt_duty_in;
      res_new.rt_dir  = rt_dir_in;
      res_new.lt_duty = lt_duty_in;
      res_new.lt_dir  = lt_dir_in;
      res_new.status  = !match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_duty_ff <= '0;
         rt_dir_ff  <= 1'b0;
         lt_duty_ff <= '0;
         lt_dir_ff  <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         rt_duty_ff <= rt_duty_in;
         rt_dir_ff  <= rt_dir_in;
         lt_duty_ff <= lt_duty_in;
         lt_dir_ff  <= lt_dir_in;
         if (take) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(take) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff[wr_ptr_ff] <= res_new;
      end
   end

   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count overflow");

   a_drive_kept: assert property (@(posedge clock) disable iff (reset)
      (take && !match) |=> $stable(rt_duty_ff) && $stable(lt_duty_ff)
         && $stable(rt_dir_ff) && $stable(lt_dir_ff))
      else $error("drive changed on check mismatch");

   a_drive_loaded: assert property (@(posedge clock) disable iff (reset)
      (take && match) |=> (rt_duty_ff == $past(new_rt_duty))
         && (lt_duty_ff == $past(new_lt_duty)))
      else $error("drive not loaded on check match");

endmodule

`default_nettype wire

// ===== rtl/core/ascii_motor_command_parser.sv =====
// Top level of the ASCII motor command parser: parser front, line queue
// and drive back end. Depends on amcp_pkg, amcp_front, amcp_line_queue, amcp_back.
//
// Usage:
//   Request channel: drive req_rx_byte and raise req_push; a byte is taken
//   at each clock edge where req_push is high and req_full is low. Bytes
//   form lines "left:right:check\n"; one byte can be taken every cycle.
//   Response channel: while rsp_empty is low the oldest result sits on the
//   rsp_ ports; raise rsp_pop to take it. One result follows each newline,
//   nothing follows any other byte.
//   Path: a newline pushes its line record into the line queue at the edge
//   that takes it; the drive check then registers its result in the result queue.
//   Throughput: one byte per cycle while req_full is low; the drive check handles
//   one line per cycle, so the two-entry queues only fill when rsp_pop is held low.
//   Stall: with the result queue full the line queue backs up, and once it
//   is full req_full rises and holds all bytes until a result is popped.
//   Reset: synchronous; clears the parser, both queues and the held drive
//   (speeds 0, directions 0).
`default_nettype none

module ascii_motor_command_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_rx_byte,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_rt_duty,
   output logic             rsp_rt_dir,
   output logic [7:0]       rsp_lt_duty,
   output logic             rsp_lt_dir,
   output logic             rsp_status
);
   import amcp_pkg::*;

   logic       req_take;
   logic       line_push;
   line_type   line_in_data;
   logic       line_full;
   logic       line_empty;
   logic       line_pop;
   line_type   line_out_data;
   result_type res_data;

   // hold all bytes while the line queue cannot take a newline
   assign req_full = line_full;
   assign req_take = req_push && !line_full;

   amcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_take (req_take),
      .rx_byte   (req_rx_byte),
      .line_push (line_push),
      .line_data (line_in_data)
   );

   amcp_line_queue u_line_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (line_push),
      .push_data (line_in_data),
      .full      (line_full),
      .empty     (line_empty),
      .pop       (line_pop),
      .pop_data  (line_out_data)
   );

   amcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_valid (!line_empty),
      .line_data  (line_out_data),
      .line_pop   (line_pop),
      .res_empty  (rsp_empty),
      .res_pop    (rsp_pop),
      .res_data   (res_data)
   );

   assign rsp_rt_duty = res_data.rt_duty;
   assign rsp_rt_dir  = res_data.rt_dir;
   assign rsp_lt_duty = res_data.lt_duty;
   assign rsp_lt_dir  = res_data.lt_dir;
   assign rsp_status  = res_data.status;

endmodule

`default_nettype wire

// ===== test/tb_ascii_motor_command_parser.sv =====
// Testbench for ascii_motor_command_parser: byte-stream stimulus with a self-checking
// line predictor and in-order result checking on the queue-style response port.
// Depends on amcp_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_ascii_motor_command_parser;

   import amcp_pkg::*;

   localparam int DRIVE_MAX     = int'(DRIVE_LIMIT);
   localparam int RANDOM_BYTES  = 900;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 8;
   localparam int MAX_PRINTED   = 30;

   // One byte of stimulus; a newline may carry a hand-written expectation.
   typedef struct packed {
      logic [7:0] data;
      logic       known;
      result_type want;
   } stim_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_rt_duty;
   logic       rsp_rt_dir;
   logic [7:0] rsp_lt_duty;
   logic       rsp_lt_dir;
   logic       rsp_status;

   ascii_motor_command_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_rt_duty (rsp_rt_duty),
      .rsp_rt_dir  (rsp_rt_dir),
      .rsp_lt_duty (rsp_lt_duty),
      .rsp_lt_dir  (rsp_lt_dir),
      .rsp_status  (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Directed table. Rows with a typed expectation sit right after reset,
   // so the held drive is easy to follow by hand; the rest go through the
   // predictor. A '@' in the row text is sent as a NUL byte.
   // ------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 17;

   string directed_text [DIRECTED_ROWS] = '{
      "\n",                       // empty line right after reset: all fields zero, match
      "300:-300:0\n",             // clamp both ways to the drive limit
      "-255:255:0\n",             // exact limits, both directions flip
      "1:2:4\n",                  // bad check: drive held, status set
      "+12:-7:5\n",               // explicit signs
      "::\t 40:: 2:42\n",         // colons before a field are skipped
      " :9:9\n",                  // field of whitespace only ends on a colon as zero
      "7\n",                      // short line, right and check missing
      "7:3\n",                    // short line, check missing
      "70000:-4464:0\n",          // digits wrap modulo 2^16
      "32767:32767:65534\n",      // sum is taken unwrapped, check field wraps
      "-32768:-1:-32769\n",       // most negative value
      "5x9:3 4:8:junk\n",         // trailing junk, colon inside the check field
      "@3:\3772:5\n",             // NUL and a byte above 127 end a field
      "-:+:0\n",                  // sign with no digits reads as zero
      "\t\013\014\015 6:\015-6:0\n",  // every whitespace code
      "255:1:256\n"
   };

   bit directed_known [DIRECTED_ROWS] = '{
      1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };

   // {rt_duty, rt_dir, lt_duty, lt_dir, status}
   result_type directed_want [DIRECTED_ROWS] = '{
      {8'd0,   1'b0, 8'd0,   1'b1, 1'b0},
      {8'd255, 1'b0, 8'd255, 1'b0, 1'b0},
      {8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
      {8'd255, 1'b1, 8'd255, 1'b1, 1'b1},
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0
   };

   // ------------------------------------------------------------------
   // Line predictor state: mirrors the parser and the held drive.
   // ------------------------------------------------------------------
   logic [1:0]  field_q;
   phase_type   phase_q;
   logic        neg_q;
   logic [15:0] acc_q;
   logic [15:0] left_q;
   logic [15:0] right_q;
   logic [8:0]  right_drv;
   logic [8:0]  left_drv;

   stim_byte_type line_bytes [$];
   result_type    pending_drive_q [$];

   int  sent_count    = 0;
   int  line_count    = 0;
   int  results_seen  = 0;
   int  rejected_seen = 0;
   int  full_stalls   = 0;
   int  error_count   = 0;
   bit  run_go        = 1'b0;
   bit  hold_arm      = 1'b0;
   bit  hold_done     = 1'b0;
   int  hold_left     = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic clear_drive_state();
      field_q   = FIELD_LEFT;
      phase_q   = PHASE_SKIP;
      neg_q     = 1'b0;
      acc_q     = '0;
      left_q    = '0;
      right_q   = '0;
      right_drv = '0;
      left_drv  = '0;
   endtask

   // Clamp to the drive limit and split into direction and magnitude.
   function automatic logic [8:0] drive_word(input int v, input bit dir_pos);
      int   m;
      logic d;
      m = (v > DRIVE_MAX) ? DRIVE_MAX : v;
      if (m < -DRIVE_MAX) m = -DRIVE_MAX;
      d = (m > 0) ? dir_pos : !dir_pos;
      if (m < 0) m = -m;
      return {d, m[7:0]};
   endfunction

   // Advance the predictor by one byte; a newline yields the drive result.
   task automatic parse_rx_byte(input logic [7:0] c, output bit produced,
                                output result_type res);
      logic [15:0] v;
      logic [15:0] chk;
      int          l;
      int          r;
      int          chk_int;
      logic        st;
      produced = 1'b0;
      res      = '0;
      v = neg_q ? 16'(16'd0 - acc_q) : acc_q;
      if (c == NL_BYTE) begin
         chk = '0;
         case (field_q)
            FIELD_LEFT: begin
               left_q  = v;
               right_q = '0;
            end
            FIELD_RIGHT: right_q = v;
            default: chk = v;
         endcase
         l       = int'($signed(left_q));
         r       = int'($signed(right_q));
         chk_int = int'($signed(chk));
         // Compare at full precision: the sum is never wrapped.
         if (chk_int == l + r) begin
            right_drv = drive_word(r, 1'b1);
            left_drv  = drive_word(l, 1'b0);
            st = 1'b0;
         end else begin
            st = 1'b1;
         end
         res = {right_drv[7:0], right_drv[8], left_drv[7:0], left_drv[8], st};
         produced = 1'b1;
         field_q = FIELD_LEFT;
         left_q  = '0;
         right_q = '0;
         phase_q = PHASE_SKIP;
         neg_q   = 1'b0;
         acc_q   = '0;
      end else if (c == COLON_BYTE && field_q < FIELD_CHECK) begin
         // A colon before the field starts is skipped; otherwise close the field.
         if (phase_q != PHASE_SKIP) begin
            if (field_q == FIELD_LEFT) left_q = v;
            else right_q = v;
            field_q = field_q + 2'd1;
            phase_q = PHASE_SKIP;
            neg_q   = 1'b0;
            acc_q   = '0;
         end
      end else if (phase_q == PHASE_SKIP || phase_q == PHASE_BLANK) begin
         if (c == SPACE_BYTE || (c >= TAB_BYTE && c <= CR_BYTE)) begin
            phase_q = PHASE_BLANK;
         end else if (c == PLUS_BYTE || c == MINUS_BYTE) begin
            neg_q   = (c == MINUS_BYTE);
            phase_q = PHASE_NUMBER;
         end else if (c >= ZERO_BYTE && c <= NINE_BYTE) begin
            acc_q   = {8'd0, 8'(c - ZERO_BYTE)};
            phase_q = PHASE_NUMBER;
         end else begin
            phase_q = PHASE_DONE;
         end
      end else if (phase_q == PHASE_NUMBER) begin
         if (c >= ZERO_BYTE && c <= NINE_BYTE) acc_q = acc_q * 16'd10 + {8'd0, 8'(c - ZERO_BYTE)};
         else phase_q = PHASE_DONE;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] data, input bit known, input result_type want);
      line_bytes.push_back({data, known, want});
      if (data == NL_BYTE) line_count++;
   endtask

   // Append a text line; the hand-written expectation rides on the newline.
   task automatic add_text(input string s, input bit known, input result_type want);
      logic [7:0] b;
      for (int i = 0; i < s.len(); i++) begin
         b = s[i];
         if (b == "@") b = 8'd0;
         if (i == s.len() - 1 && b == NL_BYTE) push_byte(b, known, want);
         else push_byte(b, 1'b0, '0);
      end
   endtask

   // Mostly small drive values, some limits, some full int16, some overflowing text.
   function automatic int pick_value();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return int'($urandom_range(0, 600)) - 300;
      if (k < 70) begin
         case ($urandom_range(0, 4))
            0: return 0;
            1: return DRIVE_MAX;
            2: return -DRIVE_MAX;
            3: return DRIVE_MAX + 1;
            default: return -DRIVE_MAX - 1;
         endcase
      end
      if (k < 90) return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 199998)) - 99999;
   endfunction

   function automatic string field_text(input int v, input bit colon_ok);
      string s;
      s = "";
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 4))
            0: s = {s, " "};
            1: s = {s, "\t"};
            2: s = {s, "\015"};
            3: s = {s, "\013"};
            default: s = {s, "\014"};
         endcase
      end
      if (v < 0) s = {s, "-"};
      else if ($urandom_range(0, 3) == 0) s = {s, "+"};
      s = {s, $sformatf("%0d", (v < 0) ? -v : v)};
      // Tack on junk now and then; everything after it is ignored.
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0: s = {s, $sformatf("%c", 8'($urandom_range(97, 122)))};
            1: s = {s, " 9"};
            2: s = {s, $sformatf("%c", 8'($urandom_range(128, 255)))};
            default: s = {s, colon_ok ? ":7" : "z"};
         endcase
      end
      return s;
   endfunction

   function automatic string lead_colons();
      return ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? "::" : ":") : "";
   endfunction

   task automatic add_random_line();
      int          kind;
      int          lv;
      int          rv;
      int          cv;
      logic [15:0] lw;
      logic [15:0] rw;
      string       s;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         // Well-formed line; one time in four the check is offset by -2 to +2.
         lv = pick_value();
         rv = pick_value();
         lw = lv[15:0];
         rw = rv[15:0];
         cv = int'($signed(lw)) + int'($signed(rw));
         if ($urandom_range(0, 3) == 0) cv = cv + int'($urandom_range(0, 4)) - 2;
         s = {lead_colons(), field_text(lv, 1'b0), ":", lead_colons(), field_text(rv, 1'b0),
              ":", field_text(cv, 1'b1), "\n"};
         add_text(s, 1'b0, '0);
      end else if (kind < 88) begin
         // Broken line: newline before all fields.
         s = field_text(pick_value(), 1'b0);
         if ($urandom_range(0, 1) != 0) s = {s, ":", field_text(pick_value(), 1'b0)};
         add_text({s, "\n"}, 1'b0, '0);
      end else begin
         // Raw noise over the whole byte range, then a newline.
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
         push_byte(NL_BYTE, 1'b0, '0);
      end
   endtask

   // Idle mix by progress: sender light / receiver heavy, then swapped, then none.
   task automatic idle_split(output int snd_pct, output int rcv_pct);
      if (sent_count < line_bytes.size() / 3) begin
         snd_pct = 13;
         rcv_pct = 68;
      end else if (sent_count < (line_bytes.size() * 2) / 3) begin
         snd_pct = 68;
         rcv_pct = 13;
      end else begin
         snd_pct = 0;
         rcv_pct = 0;
      end
   endtask

   // ------------------------------------------------------------------
   // Traffic: check popped results, then predict accepted requests.
   // Both sides live in one process so the expectation queue never races.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : traffic
      result_type got;
      result_type want;
      result_type pred;
      bit         made;
      int         snd_pct;
      int         rcv_pct;
      if (reset || !run_go) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_rt_duty, rsp_rt_dir, rsp_lt_duty, rsp_lt_dir, rsp_status};
            if (pending_drive_q.size() == 0) begin
               report_mismatch("result popped with no request pending");
            end else begin
               want = pending_drive_q.pop_front();
               if (got.rt_duty !== want.rt_duty)
                  report_mismatch($sformatf("result %0d rt_duty %0d, expected %0d",
                                            results_seen, got.rt_duty, want.rt_duty));
               if (got.rt_dir !== want.rt_dir)
                  report_mismatch($sformatf("result %0d rt_dir %0b, expected %0b",
                                            results_seen, got.rt_dir, want.rt_dir));
               if (got.lt_duty !== want.lt_duty)
                  report_mismatch($sformatf("result %0d lt_duty %0d, expected %0d",
                                            results_seen, got.lt_duty, want.lt_duty));
               if (got.lt_dir !== want.lt_dir)
                  report_mismatch($sformatf("result %0d lt_dir %0b, expected %0b",
                                            results_seen, got.lt_dir, want.lt_dir));
               if (got.status !== want.status)
                  report_mismatch($sformatf("result %0d status %0b, expected %0b",
                                            results_seen, got.status, want.status));
               if (want.status) rejected_seen++;
               results_seen++;
            end
         end

         if (req_push && !req_full) begin
            parse_rx_byte(req_rx_byte, made, pred);
            // Prefer the typed expectation where the table gives one.
            if (made) pending_drive_q.push_back(line_bytes[sent_count].known ?
                                                line_bytes[sent_count].want : pred);
            sent_count++;
         end

         idle_split(snd_pct, rcv_pct);
         if (req_push && req_full) begin
            // Hold the offered request until the block takes it.
            full_stalls++;
         end else if (sent_count < line_bytes.size() && $urandom_range(0, 99) >= snd_pct) begin
            req_push    <= 1'b1;
            req_rx_byte <= line_bytes[sent_count].data;
         end else begin
            req_push <= 1'b0;
         end

         rsp_pop <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_pct);
         // Arm the long hold-off once the sender runs without gaps.
         if (!hold_arm && sent_count >= (line_bytes.size() * 3) / 4) hold_arm <= 1'b1;
      end
   end

   // Receiver hold-off: keep pop low for a long stretch so both queues fill
   // and req_full pushes back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin
      clear_drive_state();
      for (int i = 0; i < DIRECTED_ROWS; i++)
         add_text(directed_text[i], directed_known[i], directed_want[i]);
      while (line_bytes.size() < RANDOM_BYTES) add_random_line();

      // Apply reset once, then release the traffic process.
      repeat (10) @(posedge clock);
      reset  <= 1'b0;
      run_go <= 1'b1;

      // Drain: all requests taken and every result checked.
      do @(negedge clock);
      while (sent_count < line_bytes.size() || pending_drive_q.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d bytes in %0d command lines; %0d results checked, %0d with a bad check.",
               sent_count, line_count, results_seen, rejected_seen);
      $display("Request side stalled on a full block for %0d cycles.", full_stalls);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timeout with %0d results still pending.", pending_drive_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/amcp_pkg.sv
rtl/core/amcp_front.sv
rtl/core/amcp_line_queue.sv
rtl/core/amcp_back.sv
rtl/core/ascii_motor_command_parser.sv
test/tb_ascii_motor_command_parser.sv
